// ===== sv/lir_pkg.sv =====
// lir_pkg: shared constants, types and sequencer states for the linear interpolation resampler
// no dependencies; compiled first
`default_nettype none

package lir_pkg;

  localparam int BUFFER_SAMPLES = 4096;
  localparam int CHANNEL_LIMIT  = 8;
  localparam int SAMPLE_BITS    = 16;

  localparam int ADDR_W      = $clog2(BUFFER_SAMPLES);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int CHAN_W      = 3;
  localparam int CH_CNT_W    = 4;
  localparam int RATE_W      = 24;
  localparam int FRAC_W      = 16;
  localparam int WHOLE_W     = RATE_W - FRAC_W + 1;
  localparam int PROD_W      = SAMPLE_BITS + 1 + FRAC_W + 1;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 24;
  localparam int DIV_STEPS   = COUNT_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_RATE_STEP     = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = CFG_INDEX_W'(1);

  localparam logic [RATE_W-1:0]   RATE_STEP_RESET     = RATE_W'(65536);
  localparam logic [CH_CNT_W-1:0] CHANNEL_COUNT_RESET = CH_CNT_W'(1);

  localparam logic CMD_PUSH    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] pcm_t;
  typedef logic [ADDR_W-1:0]             addr_t;
  typedef logic [COUNT_W-1:0]            count_t;
  typedef logic [CHAN_W-1:0]             chan_t;
  typedef logic [CH_CNT_W-1:0]           ch_cnt_t;
  typedef logic [RATE_W-1:0]             rate_t;
  typedef logic [FRAC_W-1:0]             frac_t;
  typedef logic [CFG_INDEX_W-1:0]        cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]         cfg_data_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD1,
    S_RD2,
    S_MUL,
    S_OUT,
    S_UPD
  } state_t;

  typedef struct packed {
    logic    start;
    count_t  dividend;
    ch_cnt_t divisor;
  } div_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    count_t quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/lir_if.sv =====
// lir_if: valid/ready channel interfaces for items (pushes and requests), results and register writes
// depends on lir_pkg
`default_nettype none

interface lir_item_if;
  import lir_pkg::*;
  logic    valid;
  logic    ready;
  logic    cmd;
  pcm_t    sample_in;
  modport source(output valid, cmd, sample_in, input ready);
  modport sink(input valid, cmd, sample_in, output ready);
endinterface

interface lir_result_if;
  import lir_pkg::*;
  logic    valid;
  logic    ready;
  pcm_t    sample_out;
  chan_t   channel;
  logic    last;
  modport source(output valid, sample_out, channel, last, input ready);
  modport sink(input valid, sample_out, channel, last, output ready);
endinterface

interface lir_cfg_if;
  import lir_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/lir_divider.sv =====
// lir_divider: restoring divider, one quotient bit per cycle, sample count over channel count
// depends on lir_pkg
`default_nettype none

module lir_divider (
  input  logic              clk,
  input  logic              rst,
  input  lir_pkg::div_req_t req,
  output lir_pkg::div_rsp_t rsp
);
  import lir_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  count_t               dvd;
  count_t               quo;
  ch_cnt_t              dsr;
  logic [CH_CNT_W:0]    rem;
  logic [CH_CNT_W:0]    trial;
  logic                 fits;

  assign trial = {rem[CH_CNT_W-1:0], dvd[COUNT_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[COUNT_W-2:0], 1'b0};
      quo <= {quo[COUNT_W-2:0], fits};
      rem <= fits ? (trial - {1'b0, dsr}) : trial;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== sv/lir_interp.sv =====
// lir_interp: shared interpolation unit, registered difference times fraction, then add
// depends on lir_pkg
`default_nettype none

module lir_interp (
  input  logic           clk,
  input  logic           load,
  input  lir_pkg::pcm_t  s1,
  input  lir_pkg::pcm_t  s2,
  input  lir_pkg::frac_t frac,
  output lir_pkg::pcm_t  y
);
  import lir_pkg::*;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_W:0]        frac_s;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      prod_q;
  pcm_t                          s1_q;

  assign diff   = {s2[SAMPLE_BITS-1], s2} - {s1[SAMPLE_BITS-1], s1};
  assign frac_s = {1'b0, frac};
  assign prod   = diff * frac_s;

  always_ff @(posedge clk) begin
    if (load) begin
      s1_q   <= s1;
      prod_q <= prod;
    end
  end

  // low bits of the floored shift are enough for a wrapped sum
  assign y = s1_q + pcm_t'(prod_q[SAMPLE_BITS+FRAC_W-1:FRAC_W]);

endmodule

`default_nettype wire

// ===== sv/linear_interp_resampler_top.sv =====
// linear_interp_resampler_top: multichannel linear interpolation resampler with sample store
// depends on lir_pkg, lir_if, lir_divider, lir_interp
// push: stored unless the store is full, next item taken in the following cycle, no result
// request: accept, frame count division, then per channel S_RD1, S_RD2, S_MUL and S_OUT on the
//   store read port and multiplier, with S_OUT waiting out output stalls, then the phase update;
//   no new item is taken until the sequencer is back in S_IDLE
// reset (rst, synchronous): heads, count and phase cleared, rate_step 1.0, one channel
`default_nettype none

module linear_interp_resampler_top (
  input  logic         clk,
  input  logic         rst,
  lir_item_if.sink     item,
  lir_result_if.source result,
  lir_cfg_if.sink      cfg
);
  import lir_pkg::*;

  state_t  state;
  state_t  state_next;
  rate_t   rate_step;
  ch_cnt_t channel_count;
  addr_t   read_head;
  addr_t   write_head;
  count_t  count;
  frac_t   frac;
  chan_t   chan;
  count_t  avail;
  pcm_t    s1_reg;
  pcm_t    rd_data;
  addr_t   rd_addr;
  pcm_t    mem [BUFFER_SAMPLES];

  ch_cnt_t ch;
  logic    has1;
  logic    has2;
  logic    is_last;
  logic    item_acc;
  logic    push_we;
  logic    out_free;
  logic    out_load;
  logic    interp_load;
  logic    div_start;
  pcm_t    s2_sel;
  pcm_t    y;

  logic                out_valid;
  pcm_t                out_sample;
  chan_t               out_chan;
  logic                out_last;

  logic [RATE_W:0]     pos;
  logic [WHOLE_W-1:0]  whole;
  logic [WHOLE_W-1:0]  take;
  count_t              take_ch;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign ch = (channel_count == '0) ? CH_CNT_W'(1) :
              (channel_count > CH_CNT_W'(CHANNEL_LIMIT)) ? CH_CNT_W'(CHANNEL_LIMIT) :
              channel_count;
  assign has1     = avail != '0;
  assign has2     = avail > COUNT_W'(1);
  assign is_last  = {1'b0, chan} == ch - CH_CNT_W'(1);
  assign item_acc = item.valid && item.ready;
  assign push_we  = item_acc && (item.cmd == CMD_PUSH) && (count < COUNT_W'(BUFFER_SAMPLES));
  assign out_free = !out_valid || result.ready;
  assign s2_sel   = has2 ? rd_data : s1_reg;

  assign pos     = {{(RATE_W - FRAC_W + 1){1'b0}}, frac} + {1'b0, rate_step};
  assign whole   = pos[RATE_W:FRAC_W];
  assign take    = (COUNT_W'(whole) < avail) ? whole : WHOLE_W'(avail);
  assign take_ch = COUNT_W'(take) * COUNT_W'(ch);

  assign div_req.start    = div_start;
  assign div_req.dividend = count;
  assign div_req.divisor  = ch;

  assign cfg.ready = 1'b1;

  lir_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lir_interp u_interp (
    .clk  (clk),
    .load (interp_load),
    .s1   (s1_reg),
    .s2   (s2_sel),
    .frac (frac),
    .y    (y)
  );

  always_comb begin
    state_next  = state;
    item.ready  = 1'b0;
    div_start   = 1'b0;
    interp_load = 1'b0;
    out_load    = 1'b0;
    rd_addr     = read_head + addr_t'(chan);
    case (state)
      S_IDLE: begin
        item.ready = 1'b1;
        if (item.valid && item.cmd == CMD_REQUEST) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_RD1;
        end
      end
      S_RD1: begin
        state_next = S_RD2;
      end
      S_RD2: begin
        rd_addr    = read_head + addr_t'(ch) + addr_t'(chan);
        state_next = S_MUL;
      end
      S_MUL: begin
        interp_load = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = is_last ? S_UPD : S_RD1;
        end
      end
      S_UPD: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rate_step     <= RATE_STEP_RESET;
      channel_count <= CHANNEL_COUNT_RESET;
      read_head     <= '0;
      write_head    <= '0;
      count         <= '0;
      frac          <= '0;
      chan          <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_RATE_STEP:     rate_step     <= cfg.data[RATE_W-1:0];
          REG_CHANNEL_COUNT: channel_count <= cfg.data[CH_CNT_W-1:0];
          default: ;
        endcase
      end
      if (push_we) begin
        write_head <= write_head + addr_t'(1);
        count      <= count + COUNT_W'(1);
      end
      if (div_start) begin
        chan <= '0;
      end else if (out_load && !is_last) begin
        chan <= chan + CHAN_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_UPD) begin
        read_head <= read_head + take_ch[ADDR_W-1:0];
        count     <= count - take_ch;
        frac      <= pos[FRAC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_rsp.done) begin
      avail <= div_rsp.quotient;
    end
    if (state == S_RD2) begin
      s1_reg <= has1 ? rd_data : '0;
    end
    if (out_load) begin
      out_sample <= y;
      out_chan   <= chan;
      out_last   <= is_last;
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (push_we) begin
      mem[write_head] <= item.sample_in;
    end
    rd_data <= mem[rd_addr];
  end

  assign result.valid      = out_valid;
  assign result.sample_out = out_sample;
  assign result.channel    = out_chan;
  assign result.last       = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(BUFFER_SAMPLES))
    else $error("stored count above store size");

  a_heads_consistent: assert property (@(posedge clk) disable iff (rst)
    write_head == read_head + count[ADDR_W-1:0])
    else $error("write head out of step with read head and count");

  a_chan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_DIV) |-> ({1'b0, chan} < ch))
    else $error("channel index beyond active channels");

  a_last_to_update: assert property (@(posedge clk) disable iff (rst)
    (out_load && is_last) |=> (state == S_UPD && result.valid && result.last))
    else $error("frame end not followed by phase update");

  a_no_push_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !push_we)
    else $error("store written during a request");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for linear_interp_resampler_top, directed table, random phases, then a held-off burst
// depends on lir_pkg, lir_if and linear_interp_resampler_top

module tb_top;
  import lir_pkg::*;

  localparam int CLK_HALF_NS   = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int IDLE_SETTLE   = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 20;
  localparam int RANDOM_PHASES = 4;
  localparam int MAX_REPORTS   = 10;
  localparam int DIRECTED_ROWS = 30;

  typedef struct packed {
    pcm_t    sample_out;
    chan_t   channel;
    logic    last;
  } out_sample_t;

  typedef enum logic [1:0] {ROW_PUSH, ROW_REQ, ROW_RATE, ROW_CHANS} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [23:0] value;
    logic        fixed;
    pcm_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  lir_item_if   item_bus ();
  lir_result_if res_bus ();
  lir_cfg_if    cfg_bus ();

  linear_interp_resampler_top uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (res_bus),
    .cfg    (cfg_bus)
  );

  always #CLK_HALF_NS clk = ~clk;

  // resampler state as predicted
  pcm_t    model_store [BUFFER_SAMPLES];
  addr_t   model_rd;
  addr_t   model_wr;
  count_t  model_held;
  frac_t   model_phase;
  rate_t   model_rate;
  ch_cnt_t model_chans;

  out_sample_t expected_samples [$];
  int failures = 0;
  int quiet_cycles = 0;
  int hold_orders = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b1;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_REQ,   24'h000000, 1'b1, 16'h0000},
    '{ROW_PUSH,  24'h007FFF, 1'b0, 16'h0000},
    '{ROW_REQ,   24'h000000, 1'b1, 16'h7FFF},
    '{ROW_PUSH,  24'h008000, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h007FFF, 1'b0, 16'h0000},
    '{ROW_REQ,   24'h000000, 1'b1, 16'h8000},
    '{ROW_RATE,  24'h000001, 1'b0, 16'h0000},
    '{ROW_REQ,   24'h000000, 1'b1, 16'h7FFF},
    '{ROW_PUSH,  24'h008000, 1'b0, 16'h0000},
    '{ROW_REQ,   24'h000000, 1'b0, 16'h0000},
    '{ROW_RATE,  24'hFFFFFF, 1'b0, 16'h0000},
    '{ROW_REQ,   24'h000000, 1'b0, 16'h0000},
    '{ROW_REQ,   24'h000000, 1'b1, 16'h0000},
    '{ROW_CHANS, 24'h000008, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h000064, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h00FFFF, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h000000, 1'b0, 16'h0000},
    '{ROW_REQ,   24'h000000, 1'b0, 16'h0000},
    '{ROW_CHANS, 24'h000000, 1'b0, 16'h0000},
    '{ROW_REQ,   24'h000000, 1'b0, 16'h0000},
    '{ROW_CHANS, 24'h00000F, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h005555, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h00AAAA, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h000001, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h00FFFE, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h007FFF, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h008000, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h001234, 1'b0, 16'h0000},
    '{ROW_PUSH,  24'h00EDCB, 1'b0, 16'h0000},
    '{ROW_REQ,   24'h000000, 1'b0, 16'h0000}
  };

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  function automatic pcm_t random_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return pcm_t'($urandom);
    endcase
  endfunction

  // push stores a sample unless the store is full, request interpolates one frame and advances the phase
  task automatic resample_model(input logic c, input pcm_t s, input logic fixed,
                                input pcm_t want);
    int ch;
    int frames;
    int whole;
    int take;
    int k;
    int s1;
    int s2;
    longint prod;
    logic [RATE_W:0] pos;
    out_sample_t exp_s;
    if (c == CMD_PUSH) begin
      if (model_held < BUFFER_SAMPLES) begin
        model_store[model_wr] = s;
        model_wr = model_wr + 1'b1;
        model_held = model_held + 1'b1;
      end
    end else begin
      if (model_chans == 0) ch = 1;
      else if (model_chans > CHANNEL_LIMIT) ch = CHANNEL_LIMIT;
      else ch = model_chans;
      frames = model_held / ch;
      for (k = 0; k < ch; k++) begin
        s1 = 0;
        if (frames >= 1) s1 = model_store[addr_t'(model_rd + k)];
        if (frames >= 2) s2 = model_store[addr_t'(model_rd + ch + k)];
        else s2 = s1;
        prod = longint'(s2 - s1) * longint'(model_phase);
        exp_s.sample_out = pcm_t'(s1 + int'(prod >>> 16));
        if (fixed && k == 0) exp_s.sample_out = want;
        exp_s.channel = chan_t'(k);
        exp_s.last = (k == ch - 1);
        expected_samples = {expected_samples, exp_s};
      end
      pos = {1'b0, model_rate} + model_phase;
      whole = pos >> FRAC_W;
      take = (whole < frames) ? whole : frames;
      model_rd = addr_t'(model_rd + take * ch);
      model_held = model_held - count_t'(take * ch);
      model_phase = pos[FRAC_W-1:0];
    end
  endtask

  task automatic send_item(input logic c, input pcm_t s, input logic fixed,
                           input pcm_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (sender_gaps) begin
        item_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    burst_left--;
    item_bus.valid <= 1'b1;
    item_bus.cmd <= c;
    item_bus.sample_in <= s;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    resample_model(c, s, fixed, want);
  endtask

  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input cfg_data_t val);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_RATE_STEP:     model_rate = val[RATE_W-1:0];
      REG_CHANNEL_COUNT: model_chans = val[CH_CNT_W-1:0];
      default: ;
    endcase
  endtask

  // result side: random stall modes, plus a long hold-off on demand
  initial begin : result_sink
    int mode;
    int mode_left;
    int hold_seen;
    int sink_cycle;
    mode = 0;
    mode_left = 0;
    hold_seen = 0;
    sink_cycle = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      sink_cycle++;
      if (hold_seen != hold_orders) begin
        hold_seen = hold_orders;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: res_bus.ready <= 1'b1;
          1: res_bus.ready <= ($urandom_range(0, 3) != 0);
          2: res_bus.ready <= ($urandom_range(0, 3) == 0);
          default: res_bus.ready <= ((sink_cycle % 9) < 5);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    out_sample_t exp_s;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (expected_samples.size() == 0) begin
        note_failure($sformatf("unexpected result sample %0d channel %0d last %0b",
                               res_bus.sample_out, res_bus.channel, res_bus.last));
      end else begin
        exp_s = expected_samples.pop_front();
        if (res_bus.sample_out !== exp_s.sample_out || res_bus.channel !== exp_s.channel ||
            res_bus.last !== exp_s.last)
          note_failure($sformatf("expected %0d/ch%0d/last%0b, got %0d/ch%0d/last%0b",
                                 exp_s.sample_out, exp_s.channel, exp_s.last,
                                 res_bus.sample_out, res_bus.channel, res_bus.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int row;
    int phase;
    int sent;
    int active;
    rate_t rate;
    ch_cnt_t chans;
    rst <= 1'b1;
    item_bus.valid <= 1'b0;
    item_bus.cmd <= CMD_PUSH;
    item_bus.sample_in <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_RATE_STEP;
    cfg_bus.data <= '0;
    model_rd = '0;
    model_wr = '0;
    model_held = '0;
    model_phase = '0;
    model_rate = RATE_STEP_RESET;
    model_chans = CHANNEL_COUNT_RESET;
    for (row = 0; row < BUFFER_SAMPLES; row++) model_store[row] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      case (directed_rows[row].kind)
        ROW_PUSH:
          send_item(CMD_PUSH, pcm_t'(directed_rows[row].value[15:0]),
                    directed_rows[row].fixed, directed_rows[row].want);
        ROW_REQ:
          send_item(CMD_REQUEST, random_sample(), directed_rows[row].fixed,
                    directed_rows[row].want);
        ROW_RATE: write_reg(REG_RATE_STEP, directed_rows[row].value);
        default:  write_reg(REG_CHANNEL_COUNT, directed_rows[row].value);
      endcase
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 7))
        0: rate = 24'h000001;
        1: rate = 24'h004000;
        2: rate = 24'h008000;
        3: rate = 24'h010000;
        4: rate = 24'h018000;
        5: rate = 24'h020000;
        6: rate = 24'hFFFFFF;
        default: rate = rate_t'($urandom_range(1, 24'h040000));
      endcase
      case ($urandom_range(0, 9))
        0: chans = 4'd0;
        1: chans = ch_cnt_t'($urandom_range(9, 15));
        default: chans = ch_cnt_t'($urandom_range(1, CHANNEL_LIMIT));
      endcase
      write_reg(REG_RATE_STEP, cfg_data_t'(rate));
      write_reg(REG_CHANNEL_COUNT, cfg_data_t'(chans));
      if (chans == 0) active = 1;
      else if (chans > CHANNEL_LIMIT) active = CHANNEL_LIMIT;
      else active = chans;
      sender_gaps = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(logic'($urandom_range(0, 1)), random_sample(), 1'b0, '0);
          sent++;
        end else begin
          repeat (active) send_item(CMD_PUSH, random_sample(), 1'b0, '0);
          sent += active;
          repeat ($urandom_range(0, 2)) begin
            send_item(CMD_REQUEST, random_sample(), 1'b0, '0);
            sent++;
          end
        end
      end
    end

    // back up the block while results are held off
    write_reg(REG_CHANNEL_COUNT, cfg_data_t'(CHANNEL_LIMIT));
    write_reg(REG_RATE_STEP, cfg_data_t'(RATE_STEP_RESET));
    sender_gaps = 1'b0;
    repeat (3 * CHANNEL_LIMIT) send_item(CMD_PUSH, random_sample(), 1'b0, '0);
    hold_orders++;
    repeat (8) send_item(CMD_REQUEST, random_sample(), 1'b0, '0);

    item_bus.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    if (expected_samples.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_samples.size()));
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lir_pkg.sv
sv/lir_if.sv
sv/lir_divider.sv
sv/lir_interp.sv
sv/linear_interp_resampler_top.sv
sim/tb_top.sv
